// ===== sv/mspp_pkg.sv =====
`default_nettype none

package mspp_pkg;

   // Default number formats.
   localparam int FRAC_BITS_DEF      = 16;
   localparam int DUTY_FRAC_BITS_DEF = 14;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_GAIN    = 3'd0,
      CSR_PROP_GAIN     = 3'd1,
      CSR_INTEG_GAIN_DT = 3'd2,
      CSR_DERIV_GAIN_FS = 3'd3,
      CSR_PWM_PERIOD    = 3'd4
   } csr_index_type;

   // Shared multiplier: 33-bit magnitude times 32-bit gain or PWM period.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   // Signed gain term and the wider accumulator that sums two terms and the integrator.
   localparam int TERM_W  = PROD_W + 1;
   localparam int ACC_W   = TERM_W + 2;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   // Microprogram length and step counter.
   localparam int UCODE_STEPS = 18;
   localparam int PC_W        = $clog2(UCODE_STEPS);
   localparam logic [PC_W-1:0] STEP_IDLE = '0;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_PUBLISH
   } seq_op_type;

   typedef enum logic [1:0] {
      A_CNT,
      A_ERR,
      A_DIFF,
      A_DUTY
   } mul_a_type;

   typedef enum logic [2:0] {
      B_SPEED_GAIN,
      B_PROP,
      B_INTEG,
      B_DERIV,
      B_PERIOD
   } mul_b_type;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_RAW,
      TERM_SHIFT
   } term_op_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_SPEED,
      ALU_ERR,
      ALU_DIFF,
      ALU_INTEG,
      ALU_ACC_LOAD,
      ALU_ACC_ADD_TERM,
      ALU_ACC_ADD_INTEG,
      ALU_CLAMP,
      ALU_DUTY
   } alu_op_type;

   // One control word of the microprogram.
   typedef struct packed {
      seq_op_type  seq;
      mul_a_type   mul_a;
      mul_b_type   mul_b;
      logic        mul_load;
      term_op_type term_op;
      alu_op_type  alu_op;
   } ucode_type;

   // Conditions the sequencer branches on.
   typedef struct packed {
      logic req_fire;
      logic out_free;
   } seq_cond_type;

   // Sequencer outputs toward the datapath and the handshake logic.
   typedef struct packed {
      ucode_type word;
      logic      idle;
      logic      publish;
   } seq_status_type;

   localparam ucode_type UCODE_NOP = '{
      seq:      SEQ_NEXT,
      mul_a:    A_CNT,
      mul_b:    B_SPEED_GAIN,
      mul_load: 1'b0,
      term_op:  TERM_NONE,
      alu_op:   ALU_NOP
   };

   // Control store. The multiplier registers its operands and then its product,
   // so each term is taken from the product register after both have loaded.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] step);
      ucode_type w;
      w = UCODE_NOP;
      case (step)
         PC_W'(0): begin
            w.seq = SEQ_WAIT_REQ;
         end
         PC_W'(1): begin
            w.mul_load = 1'b1;
            w.mul_a    = A_CNT;
            w.mul_b    = B_SPEED_GAIN;
         end
         PC_W'(2): begin
            w.alu_op = ALU_NOP;
         end
         PC_W'(3): begin
            w.term_op = TERM_RAW;
         end
         PC_W'(4): begin
            w.alu_op = ALU_SPEED;
         end
         PC_W'(5): begin
            w.alu_op = ALU_ERR;
         end
         PC_W'(6): begin
            w.alu_op   = ALU_DIFF;
            w.mul_load = 1'b1;
            w.mul_a    = A_ERR;
            w.mul_b    = B_INTEG;
         end
         PC_W'(7): begin
            w.mul_load = 1'b1;
            w.mul_a    = A_ERR;
            w.mul_b    = B_PROP;
         end
         PC_W'(8): begin
            w.mul_load = 1'b1;
            w.mul_a    = A_DIFF;
            w.mul_b    = B_DERIV;
            w.term_op  = TERM_SHIFT;
         end
         PC_W'(9): begin
            w.alu_op  = ALU_INTEG;
            w.term_op = TERM_SHIFT;
         end
         PC_W'(10): begin
            w.alu_op  = ALU_ACC_LOAD;
            w.term_op = TERM_SHIFT;
         end
         PC_W'(11): begin
            w.alu_op = ALU_ACC_ADD_TERM;
         end
         PC_W'(12): begin
            w.alu_op = ALU_ACC_ADD_INTEG;
         end
         PC_W'(13): begin
            w.alu_op = ALU_CLAMP;
         end
         PC_W'(14): begin
            w.alu_op = ALU_DUTY;
         end
         PC_W'(15): begin
            w.mul_load = 1'b1;
            w.mul_a    = A_DUTY;
            w.mul_b    = B_PERIOD;
         end
         PC_W'(16): begin
            w.alu_op = ALU_NOP;
         end
         PC_W'(17): begin
            w.seq = SEQ_PUBLISH;
         end
         default: begin
            w = UCODE_NOP;
         end
      endcase
      return w;
   endfunction

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return 32'(r);
   endfunction

endpackage

`default_nettype wire

// ===== sv/motor_speed_pid_pwm.sv =====
`default_nettype none

// Motor speed PID controller with PWM output. Each request transaction is one
// control tick: the signed encoder count is scaled by speed_gain to a Q16.16
// measured speed, the error against target_speed drives a PID law with an
// integrator clamped to plus or minus one, and the summed drive, clamped to
// plus or minus one, gives duty (Q2.14), the PWM compare count and the two
// direction lines. The work is done by an 18-step microprogram, one wait step
// and 17 working steps, that runs every product through one shared 33 x 32
// multiplier with registered operands and a registered product. Requests are
// taken only while the program waits at its first step; the next request can be
// accepted while the previous result still waits on a stalled response channel,
// and the program holds at its last step for as long as that result has not been
// taken. Gains and period are written through the csr port; the user must write
// them only while idle, which the block itself does not enforce.

module motor_speed_pid_pwm #(
   parameter int FRAC_BITS      = mspp_pkg::FRAC_BITS_DEF,
   parameter int DUTY_FRAC_BITS = mspp_pkg::DUTY_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [mspp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mspp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [15:0]                  req_count_delta,
   input  wire logic signed [31:0]                  req_target_speed,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [15:0]                              rsp_compare_value,
   output logic                                     rsp_drive_fwd,
   output logic                                     rsp_drive_rev,
   output logic signed [15:0]                       rsp_duty,
   output logic signed [31:0]                       rsp_measured_speed
);

   mspp_pkg::seq_cond_type   seq_cond;
   mspp_pkg::seq_status_type seq_status;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   // Channel conditions for the sequencer.
   always_comb begin
      req_stall         = ~seq_status.idle;
      seq_cond.req_fire = req_valid && !req_stall;
      seq_cond.out_free = !rsp_valid_ff || !rsp_stall;
   end

   mspp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .cond   (seq_cond),
      .status (seq_status)
   );

   mspp_datapath #(
      .FRAC_BITS      (FRAC_BITS),
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_fire           (seq_cond.req_fire),
      .req_count_delta    (req_count_delta),
      .req_target_speed   (req_target_speed),
      .ctrl               (seq_status.word),
      .publish            (seq_status.publish),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_drive_fwd      (rsp_drive_fwd),
      .rsp_drive_rev      (rsp_drive_rev),
      .rsp_duty           (rsp_duty),
      .rsp_measured_speed (rsp_measured_speed)
   );

   // Response valid: set on hand-off, cleared once the transaction is taken.
   always_comb begin
      if (seq_status.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // An accepted request starts the program, which then refuses further requests.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but sequencer stayed idle");

   // After handing off a result the program returns to its waiting step.
   a_idle_after_publish: assert property (@(posedge clock) disable iff (reset)
      seq_status.publish |=> !req_stall)
      else $error("sequencer did not return to idle after hand-off");

   // Exactly one direction line is active on a valid response.
   a_direction_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_fwd != rsp_drive_rev))
      else $error("direction lines not exclusive");
`endif

endmodule

`default_nettype wire

// ===== sv/mspp_sequencer.sv =====
`default_nettype none

module mspp_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mspp_pkg::seq_cond_type  cond,
   output mspp_pkg::seq_status_type     status
);

   logic [mspp_pkg::PC_W-1:0] pc_ff;
   logic [mspp_pkg::PC_W-1:0] pc_in;
   mspp_pkg::ucode_type       word;

   // Fetch the control word of the current step.
   always_comb begin
      word = mspp_pkg::ucode_rom(pc_ff);
   end

   // Step counter with the two conditional branches of the program.
   always_comb begin
      pc_in = pc_ff;
      case (word.seq)
         mspp_pkg::SEQ_WAIT_REQ: begin
            if (cond.req_fire) begin
               pc_in = pc_ff + mspp_pkg::PC_W'(1);
            end
         end
         mspp_pkg::SEQ_PUBLISH: begin
            if (cond.out_free) begin
               pc_in = mspp_pkg::STEP_IDLE;
            end
         end
         mspp_pkg::SEQ_NEXT: begin
            pc_in = pc_ff + mspp_pkg::PC_W'(1);
         end
         default: begin
            pc_in = mspp_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= mspp_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Status toward the datapath and the channel logic.
   always_comb begin
      status.word    = word;
      status.idle    = (word.seq == mspp_pkg::SEQ_WAIT_REQ);
      status.publish = (word.seq == mspp_pkg::SEQ_PUBLISH) && cond.out_free;
   end

endmodule

`default_nettype wire

// ===== sv/mspp_datapath.sv =====
`default_nettype none

module mspp_datapath #(
   parameter int FRAC_BITS      = mspp_pkg::FRAC_BITS_DEF,
   parameter int DUTY_FRAC_BITS = mspp_pkg::DUTY_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [mspp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mspp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_fire,
   input  wire logic signed [15:0]                  req_count_delta,
   input  wire logic signed [31:0]                  req_target_speed,
   input  wire mspp_pkg::ucode_type                 ctrl,
   input  wire logic                                publish,
   output logic [15:0]                              rsp_compare_value,
   output logic                                     rsp_drive_fwd,
   output logic                                     rsp_drive_rev,
   output logic signed [15:0]                       rsp_duty,
   output logic signed [31:0]                       rsp_measured_speed
);

   localparam int AW     = mspp_pkg::ACC_W;
   localparam int TW     = mspp_pkg::TERM_W;
   localparam int PW     = mspp_pkg::PROD_W;
   localparam int MAW    = mspp_pkg::MUL_A_W;
   localparam int MBW    = mspp_pkg::MUL_B_W;
   localparam int SEL_W  = MAW + 1;
   localparam int UW     = FRAC_BITS + 2;
   localparam int DUTY_W = DUTY_FRAC_BITS + 2;
   localparam int CONV_W = UW + DUTY_W;
   localparam int SH_R   = (FRAC_BITS >= DUTY_FRAC_BITS) ? FRAC_BITS - DUTY_FRAC_BITS : 0;
   localparam int SH_L   = (FRAC_BITS >= DUTY_FRAC_BITS) ? 0 : DUTY_FRAC_BITS - FRAC_BITS;

   localparam logic signed [AW-1:0]     ONE      = AW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0]     NEG_ONE  = -ONE;
   localparam logic signed [CONV_W-1:0] RND_MASK = (CONV_W'(1) << SH_R) - CONV_W'(1);

   // Clamp to plus or minus one in the FRAC_BITS format.
   function automatic logic signed [AW-1:0] clamp_one(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      if (v > ONE) begin
         r = ONE;
      end else if (v < NEG_ONE) begin
         r = NEG_ONE;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [31:0] speed_gain_ff;
   logic [31:0] prop_gain_ff;
   logic [31:0] integ_gain_ff;
   logic [31:0] deriv_gain_ff;
   logic [15:0] pwm_period_ff;

   // Latched transaction inputs.
   logic signed [15:0] cnt_ff;
   logic signed [31:0] tgt_ff;

   // Multiplier operand and product registers.
   logic [MAW-1:0] op_a_ff;
   logic           op_neg_ff;
   logic [MBW-1:0] op_b_ff;
   logic [PW-1:0]  prod_ff;
   logic           prod_neg_ff;

   // Working registers.
   logic signed [TW-1:0]     term_ff;
   logic signed [31:0]       speed_ff;
   logic signed [31:0]       err_ff;
   logic signed [32:0]       diff_ff;
   logic signed [31:0]       last_err_ff;
   logic signed [31:0]       integ_ff;
   logic signed [AW-1:0]     acc_ff;
   logic signed [UW-1:0]     u_ff;
   logic signed [DUTY_W-1:0] duty_ff;
   logic signed [DUTY_W-1:0] duty_in;

   // Result registers.
   logic [15:0]        cmp_out_ff;
   logic signed [15:0] duty_out_ff;
   logic               fwd_ff;
   logic               rev_ff;
   logic signed [31:0] speed_out_ff;

   logic signed [SEL_W-1:0] a_sel;
   logic                    a_neg;
   logic [MAW-1:0]          a_mag;
   logic [MBW-1:0]          b_sel;
   logic [PW-1:0]           prod_shift;
   logic signed [TW-1:0]    term_mag;
   logic signed [TW-1:0]    term_in;
   logic signed [CONV_W-1:0] u_ext;
   logic signed [CONV_W-1:0] conv;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff <= 32'd65536;
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         pwm_period_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            mspp_pkg::CSR_SPEED_GAIN:    speed_gain_ff <= csr_wdata;
            mspp_pkg::CSR_PROP_GAIN:     prop_gain_ff  <= csr_wdata;
            mspp_pkg::CSR_INTEG_GAIN_DT: integ_gain_ff <= csr_wdata;
            mspp_pkg::CSR_DERIV_GAIN_FS: deriv_gain_ff <= csr_wdata;
            mspp_pkg::CSR_PWM_PERIOD:    pwm_period_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the transaction when it is accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cnt_ff <= req_count_delta;
         tgt_ff <= req_target_speed;
      end
   end

   // Operand selection; the multiplier works on magnitudes.
   always_comb begin
      case (ctrl.mul_a)
         mspp_pkg::A_CNT:  a_sel = SEL_W'(cnt_ff);
         mspp_pkg::A_ERR:  a_sel = SEL_W'(err_ff);
         mspp_pkg::A_DIFF: a_sel = SEL_W'(diff_ff);
         mspp_pkg::A_DUTY: a_sel = SEL_W'(duty_ff);
         default:          a_sel = '0;
      endcase
      a_neg = a_sel[SEL_W-1];
      a_mag = MAW'(a_neg ? -a_sel : a_sel);
      case (ctrl.mul_b)
         mspp_pkg::B_SPEED_GAIN: b_sel = speed_gain_ff;
         mspp_pkg::B_PROP:       b_sel = prop_gain_ff;
         mspp_pkg::B_INTEG:      b_sel = integ_gain_ff;
         mspp_pkg::B_DERIV:      b_sel = deriv_gain_ff;
         mspp_pkg::B_PERIOD:     b_sel = MBW'(pwm_period_ff);
         default:                b_sel = '0;
      endcase
   end

   // Two-stage multiplier: operand register, then product register.
   always_ff @(posedge clock) begin
      if (ctrl.mul_load) begin
         op_a_ff   <= a_mag;
         op_neg_ff <= a_neg;
         op_b_ff   <= b_sel;
      end
      prod_ff     <= PW'(op_a_ff) * PW'(op_b_ff);
      prod_neg_ff <= op_neg_ff;
   end

   // Signed term: truncation toward zero falls out of shifting the magnitude.
   always_comb begin
      prod_shift = prod_ff >> FRAC_BITS;
      if (ctrl.term_op == mspp_pkg::TERM_SHIFT) begin
         term_mag = signed'(TW'(prod_shift));
      end else begin
         term_mag = signed'(TW'(prod_ff));
      end
      term_in = prod_neg_ff ? -term_mag : term_mag;
   end

   always_ff @(posedge clock) begin
      if (ctrl.term_op != mspp_pkg::TERM_NONE) begin
         term_ff <= term_in;
      end
   end

   // Duty conversion from the FRAC_BITS format, truncating toward zero.
   always_comb begin
      u_ext = CONV_W'(u_ff);
      if (FRAC_BITS >= DUTY_FRAC_BITS) begin
         conv = (u_ext + (u_ff < 0 ? RND_MASK : CONV_W'(0))) >>> SH_R;
      end else begin
         conv = u_ext <<< SH_L;
      end
      duty_in = DUTY_W'(conv);
   end

   // Controller state: integrator and previous error.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         case (ctrl.alu_op)
            mspp_pkg::ALU_DIFF:  last_err_ff <= err_ff;
            mspp_pkg::ALU_INTEG: integ_ff <= 32'(clamp_one(AW'(integ_ff) + AW'(term_ff)));
            default: begin
            end
         endcase
      end
   end

   // Arithmetic steps of the control law.
   always_ff @(posedge clock) begin
      case (ctrl.alu_op)
         mspp_pkg::ALU_SPEED:         speed_ff <= mspp_pkg::sat32(AW'(term_ff));
         mspp_pkg::ALU_ERR:           err_ff <= mspp_pkg::sat32(AW'(tgt_ff) - AW'(speed_ff));
         mspp_pkg::ALU_DIFF:          diff_ff <= 33'(err_ff) - 33'(last_err_ff);
         mspp_pkg::ALU_ACC_LOAD:      acc_ff <= AW'(term_ff);
         mspp_pkg::ALU_ACC_ADD_TERM:  acc_ff <= acc_ff + AW'(term_ff);
         mspp_pkg::ALU_ACC_ADD_INTEG: acc_ff <= acc_ff + AW'(integ_ff);
         mspp_pkg::ALU_CLAMP:         u_ff <= UW'(clamp_one(acc_ff));
         mspp_pkg::ALU_DUTY:          duty_ff <= duty_in;
         default: begin
         end
      endcase
   end

   // Result register, loaded when the program hands off a finished transaction.
   always_ff @(posedge clock) begin
      if (publish) begin
         cmp_out_ff   <= 16'(prod_ff >> DUTY_FRAC_BITS);
         duty_out_ff  <= 16'(duty_ff);
         fwd_ff       <= ~duty_ff[DUTY_W-1];
         rev_ff       <= duty_ff[DUTY_W-1];
         speed_out_ff <= speed_ff;
      end
   end

   assign rsp_compare_value  = cmp_out_ff;
   assign rsp_duty           = duty_out_ff;
   assign rsp_drive_fwd      = fwd_ff;
   assign rsp_drive_rev      = rev_ff;
   assign rsp_measured_speed = speed_out_ff;

endmodule

`default_nettype wire
